// ===== rtl/csv_field_splitter_top_assert.svh =====
// Assertion macros for the CSV field splitter checker.
// Used by csv_field_splitter_chk; relies on clk and rst_n in the including scope.
`ifndef CSV_FIELD_SPLITTER_TOP_ASSERT_SVH
`define CSV_FIELD_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfs_pkg.sv =====
// Shared constants and types for the CSV field splitter.
// No dependencies; imported by the step logic and the top level.
package cfs_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic       in_quotes;
        logic       at_field_start;
        logic       held_valid;
        logic [7:0] held_char;
        logic       quote_run_odd;
        logic       after_cr;
        logic       record_open;
    } cfs_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       field_end;
        logic       record_end;
    } cfs_result_t;

    localparam cfs_state_t STATE_RESET = '{
        in_quotes:      1'b0,
        at_field_start: 1'b1,
        held_valid:     1'b0,
        held_char:      CH_NUL,
        quote_run_odd:  1'b0,
        after_cr:       1'b0,
        record_open:    1'b0
    };

endpackage

// ===== rtl/cfs_byte_if.sv =====
// Stream interfaces of the CSV field splitter: text bytes in, field beats out.
// No dependencies.
interface cfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cfs_field_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       field_end;
    logic       record_end;

    modport source (output valid, output char_valid, output out_char,
                    output field_end, output record_end, input ready);
    modport sink   (input valid, input char_valid, input out_char,
                    input field_end, input record_end, output ready);
endinterface

// ===== rtl/cfs_step.sv =====
// Next-state and result logic of the CSV field splitter for one text byte.
// Depends on cfs_pkg for the character codes and the state and result types.
module cfs_step
    import cfs_pkg::*;
(
    input  cfs_state_t  state,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output cfs_state_t  state_next,
    output cfs_result_t result,
    output logic        result_valid
);

    logic       eod;
    logic       close_char;
    cfs_result_t close_res;
    cfs_state_t  s;

    assign eod        = end_of_data || (data_byte == CH_NUL);
    assign close_char = state.held_valid && (state.held_char != CH_QUOTE);

    // Field-closing beat; record_end filled in where it is used
    always_comb
    begin
        close_res.char_valid = close_char;
        close_res.out_char   = close_char ? state.held_char : CH_NUL;
        close_res.field_end  = 1'b1;
        close_res.record_end = 1'b0;
    end

    always_comb
    begin
        s            = state;
        result       = '0;
        result_valid = 1'b0;

        if (eod)
        begin
            if (state.record_open)
            begin
                result            = close_res;
                result.record_end = 1'b1;
                result_valid      = 1'b1;
            end
            s = STATE_RESET;
        end
        else if (state.after_cr && (data_byte == CH_LF))
        begin
            // swallow LF of a CR LF pair
            s.after_cr = 1'b0;
        end
        else
        begin
            s.after_cr    = 1'b0;
            s.record_open = 1'b1;
            if (!state.in_quotes && (data_byte == CH_COMMA))
            begin
                result              = close_res;
                result_valid        = 1'b1;
                s.held_valid        = 1'b0;
                s.held_char         = CH_NUL;
                s.quote_run_odd     = 1'b0;
                s.at_field_start    = 1'b1;
            end
            else if (!state.in_quotes && ((data_byte == CH_CR) || (data_byte == CH_LF)))
            begin
                result              = close_res;
                result.record_end   = 1'b1;
                result_valid        = 1'b1;
                s.held_valid        = 1'b0;
                s.held_char         = CH_NUL;
                s.quote_run_odd     = 1'b0;
                s.at_field_start    = 1'b1;
                s.after_cr          = (data_byte == CH_CR);
                s.record_open       = 1'b0;
            end
            else
            begin
                if (data_byte == CH_QUOTE)
                begin
                    s.in_quotes = !state.in_quotes;
                end
                if (state.at_field_start && (data_byte == CH_QUOTE))
                begin
                    // drop leading quote
                    s.at_field_start = 1'b0;
                end
                else
                begin
                    s.at_field_start = 1'b0;
                    if (state.held_valid)
                    begin
                        if ((state.held_char == CH_QUOTE) && state.quote_run_odd)
                        begin
                            // drop second quote of a pair
                            s.quote_run_odd = 1'b0;
                        end
                        else
                        begin
                            s.quote_run_odd   = (state.held_char == CH_QUOTE);
                            result.char_valid = 1'b1;
                            result.out_char   = state.held_char;
                            result_valid      = 1'b1;
                        end
                    end
                    s.held_valid = 1'b1;
                    s.held_char  = data_byte;
                end
            end
        end
        state_next = s;
    end

endmodule

// ===== rtl/csv_field_splitter_top.sv =====
// Top level of the CSV field splitter: state register, result register, handshakes.
// Depends on cfs_pkg, cfs_byte_if, cfs_field_if and cfs_step.
//
// Use: text_ch carries one text byte per beat (data_byte, end_of_data); a zero
// byte or end_of_data set closes the open record and returns the parser to
// its reset state, so the next text can follow at once. field_ch carries at
// most one beat per text beat: a field character (char_valid, out_char),
// optionally flagged field_end and record_end, or a bare field_end for an
// empty field or a closing trailing quote.
// Throughput: one text beat per cycle while field_ch is not stalled; the whole step is
// a single pass of flag logic from the state register into the result register.
// Latency: a result appears on field_ch in the cycle after its text beat is
// taken; characters trail the text by one byte, since a quote is judged by
// the byte after it.
// Stall: the result register holds while field_ch.ready is low, and
// text_ch.ready drops only then; it rises again in the cycle the result is
// taken, so a new byte is accepted while the old result leaves.
// Reset: rst_n clears the parser state and empties the result register.
module csv_field_splitter_top
    import cfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfs_byte_if.sink    text_ch,
    cfs_field_if.source field_ch
);

    cfs_state_t  state_reg;
    cfs_state_t  state_next;
    cfs_result_t step_res;
    logic        step_res_valid;
    cfs_result_t res_reg;
    logic        res_valid_reg;
    logic        take;

    assign text_ch.ready = !res_valid_reg || field_ch.ready;
    assign take          = text_ch.valid && text_ch.ready;

    cfs_step u_step (
        .state        (state_reg),
        .data_byte    (text_ch.data_byte),
        .end_of_data  (text_ch.end_of_data),
        .state_next   (state_next),
        .result       (step_res),
        .result_valid (step_res_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (take && step_res_valid)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (field_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && step_res_valid)
        begin
            res_reg <= step_res;
        end
    end

    assign field_ch.valid      = res_valid_reg;
    assign field_ch.char_valid = res_reg.char_valid;
    assign field_ch.out_char   = res_reg.out_char;
    assign field_ch.field_end  = res_reg.field_end;
    assign field_ch.record_end = res_reg.record_end;

endmodule

// ===== rtl/csv_field_splitter_chk.sv =====
// Port-level checker for the CSV field splitter, bound to the top level.
// Depends on csv_field_splitter_top_assert.svh for the assertion macros.
`include "csv_field_splitter_top_assert.svh"

module csv_field_splitter_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       char_valid,
    input logic [7:0] out_char,
    input logic       field_end,
    input logic       record_end
);

    `CFS_ASSERT_SAME(a_record_has_field, out_valid && record_end, field_end,
        "record_end without field_end")
    `CFS_ASSERT_SAME(a_empty_char_zero, out_valid && !char_valid, out_char == 8'h00,
        "out_char not zero on a beat without a character")
    `CFS_ASSERT_SAME(a_stall_backpressure, out_valid && !out_ready, !in_ready,
        "text accepted while a result is stalled")
    `CFS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
        out_valid && $stable(char_valid) && $stable(out_char) && $stable(field_end)
        && $stable(record_end), "stalled result beat changed")

endmodule

bind csv_field_splitter_top csv_field_splitter_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (text_ch.valid),
    .in_ready   (text_ch.ready),
    .out_valid  (field_ch.valid),
    .out_ready  (field_ch.ready),
    .char_valid (field_ch.char_valid),
    .out_char   (field_ch.out_char),
    .field_end  (field_ch.field_end),
    .record_end (field_ch.record_end)
);
